// ===== sv/gcb_pkg.sv =====
package gcb_pkg;

    localparam int MAX_CELL_DIM = 64;
    localparam int FB_ADDR_BITS = 25;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CELL_BITS    = 7;
    localparam int SCREEN_BITS  = 13;
    localparam int STRIDE_BITS  = 14;
    localparam int GLYPH_BITS   = 64;
    localparam int PADDR_BITS   = 5;

    localparam logic [2:0] REG_CELL_COLS     = 3'd0;
    localparam logic [2:0] REG_CELL_ROWS     = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_LINE_STRIDE   = 3'd4;

    localparam logic [CELL_BITS-1:0]   RST_CELL_COLS     = 7'd8;
    localparam logic [CELL_BITS-1:0]   RST_CELL_ROWS     = 7'd16;
    localparam logic [SCREEN_BITS-1:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [SCREEN_BITS-1:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [STRIDE_BITS-1:0] RST_LINE_STRIDE   = 14'd640;

    typedef struct packed {
        logic [CELL_BITS-1:0]   cell_cols;
        logic [CELL_BITS-1:0]   cell_rows;
        logic [SCREEN_BITS-1:0] screen_width;
        logic [SCREEN_BITS-1:0] screen_height;
        logic [STRIDE_BITS-1:0] line_stride;
    } t_cfg;

    // one visible row run, ready for the pixel stepper
    typedef struct packed {
        logic [7:0]            fg;
        logic [7:0]            bg;
        logic [CELL_BITS-1:0]  gw;
        logic                  gh_ok;
        logic [CELL_BITS-1:0]  last_x;
        logic [GLYPH_BITS-1:0] bits;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/gcb_row_if.sv =====
interface gcb_row_if;
    logic        valid;
    logic        ready;
    logic [9:0]  cell_col;
    logic [9:0]  cell_line;
    logic [7:0]  fore_color;
    logic [7:0]  back_color;
    logic        inverse;
    logic [6:0]  glyph_width;
    logic [6:0]  glyph_height;
    logic [5:0]  row_index;
    logic [63:0] row_bits;

    modport source (
        output valid, cell_col, cell_line, fore_color, back_color, inverse,
               glyph_width, glyph_height, row_index, row_bits,
        input  ready
    );
    modport sink (
        input  valid, cell_col, cell_line, fore_color, back_color, inverse,
               glyph_width, glyph_height, row_index, row_bits,
        output ready
    );
endinterface

// ===== sv/gcb_pix_if.sv =====
interface gcb_pix_if #(
    parameter int ADDR_BITS = gcb_pkg::FB_ADDR_BITS
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] pixel_address;
    logic [7:0]           pixel_value;
    logic                 last_pixel;

    modport source (
        output valid, pixel_address, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_value, last_pixel,
        output ready
    );
endinterface

// ===== sv/gcb_front.sv =====
module gcb_front #(
    parameter int MAX_DIM = gcb_pkg::MAX_CELL_DIM,
    parameter int AB      = gcb_pkg::FB_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gcb_row_if.sink              i_row,
    input  gcb_pkg::t_cfg        i_cfg,
    input  logic                 i_q_full,
    output logic                 o_push,
    output gcb_pkg::t_job        o_job,
    output logic [AB-1:0]        o_addr
);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int OXW = 10 + DW;
    localparam int PYW = 10 + DW + 1;
    localparam int SW  = gcb_pkg::SCREEN_BITS;
    localparam int PRW = PYW + gcb_pkg::STRIDE_BITS + 1;

    logic [DW-1:0]  cw, ch;
    logic [PYW-1:0] py;
    logic [OXW-1:0] ox;
    logic           s1_adv, s2_adv;

    logic                         r_s1_v;
    logic [PYW-1:0]               r_py;
    logic [OXW-1:0]               r_ox;
    logic [DW-1:0]                r_cw;
    logic                         r_skip;
    logic [7:0]                   r_fg, r_bg;
    logic [gcb_pkg::CELL_BITS-1:0] r_gw;
    logic                         r_gh_ok;
    logic [gcb_pkg::GLYPH_BITS-1:0] r_bits;

    logic                 r_s2_v;
    gcb_pkg::t_job        r_job;
    logic [AB-1:0]        r_addr;

    logic                 vis;
    logic [SW-1:0]        rem, cw_s, run;
    logic [PRW-1:0]       start;

    always_comb begin
        cw = (i_cfg.cell_cols > gcb_pkg::CELL_BITS'(MAX_DIM)) ? DW'(MAX_DIM)
                                                             : DW'(i_cfg.cell_cols);
        ch = (i_cfg.cell_rows > gcb_pkg::CELL_BITS'(MAX_DIM)) ? DW'(MAX_DIM)
                                                             : DW'(i_cfg.cell_rows);
        py = PYW'(i_row.cell_line) * PYW'(ch) + PYW'(i_row.row_index);
        ox = OXW'(i_row.cell_col) * OXW'(cw);
    end

    assign s2_adv      = !r_s2_v || !i_q_full;
    assign s1_adv      = !r_s1_v || s2_adv;
    assign i_row.ready = s1_adv;

    always_comb begin
        vis   = !r_skip && (r_py < PYW'(i_cfg.screen_height))
                && (r_ox < OXW'(i_cfg.screen_width));
        rem   = i_cfg.screen_width - SW'(r_ox);
        cw_s  = SW'(r_cw);
        run   = (rem < cw_s) ? rem : cw_s;
        start = PRW'(r_py) * PRW'(i_cfg.line_stride) + PRW'(r_ox);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= i_row.valid;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v && vis;
            end
        end
        if (s1_adv && i_row.valid) begin
            r_py    <= py;
            r_ox    <= ox;
            r_cw    <= cw;
            r_skip  <= (PYW'(i_row.row_index) >= PYW'(ch)) || (cw == '0);
            r_fg    <= i_row.inverse ? i_row.back_color : i_row.fore_color;
            r_bg    <= i_row.inverse ? i_row.fore_color : i_row.back_color;
            r_gw    <= i_row.glyph_width;
            r_gh_ok <= {1'b0, i_row.row_index} < i_row.glyph_height;
            r_bits  <= i_row.row_bits;
        end
        if (s2_adv && r_s1_v) begin
            r_job.fg     <= r_fg;
            r_job.bg     <= r_bg;
            r_job.gw     <= r_gw;
            r_job.gh_ok  <= r_gh_ok;
            r_job.last_x <= gcb_pkg::CELL_BITS'(run - SW'(1));
            r_job.bits   <= r_bits;
            r_addr       <= AB'(start);
        end
    end

    assign o_push = r_s2_v && !i_q_full;
    assign o_job  = r_job;
    assign o_addr = r_addr;

endmodule

// ===== sv/gcb_queue.sv =====
module gcb_queue #(
    parameter int AB = gcb_pkg::FB_ADDR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gcb_pkg::t_job     i_job,
    input  logic [AB-1:0]     i_addr,
    input  logic              i_pop,
    output gcb_pkg::t_job     o_job,
    output logic [AB-1:0]     o_addr,
    output gcb_pkg::t_q_stat  o_stat
);
    localparam int DEPTH = gcb_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    gcb_pkg::t_job  r_job  [DEPTH];
    logic [AB-1:0]  r_addr [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
        if (i_push) begin
            r_job[r_wr]  <= i_job;
            r_addr[r_wr] <= i_addr;
        end
    end

    assign o_job        = r_job[r_rd];
    assign o_addr       = r_addr[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== sv/gcb_back.sv =====
module gcb_back #(
    parameter int AB = gcb_pkg::FB_ADDR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcb_pkg::t_job     i_job,
    input  logic [AB-1:0]     i_addr,
    input  gcb_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    gcb_pix_if.source         o_pix
);
    localparam int XW = gcb_pkg::CELL_BITS;

    logic          r_busy;
    logic [XW-1:0] r_x;
    gcb_pkg::t_job r_job;
    logic [AB-1:0] r_addr;

    logic          r_ov;
    logic [AB-1:0] r_oaddr;
    logic [7:0]    r_oval;
    logic          r_olast;

    logic adv, emit, done, on;

    assign adv   = !r_ov || o_pix.ready;
    assign emit  = r_busy && adv;
    assign done  = emit && (r_x == r_job.last_x);
    assign o_pop = !i_stat.empty && (!r_busy || done);
    assign on    = r_job.gh_ok && (r_x < r_job.gw) && r_job.bits[gcb_pkg::GLYPH_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ov <= emit;
            end
        end
        if (o_pop) begin
            r_job  <= i_job;
            r_addr <= i_addr;
            r_x    <= '0;
        end else if (emit) begin
            r_job.bits <= r_job.bits << 1;
            r_addr     <= r_addr + AB'(1);
            r_x        <= r_x + XW'(1);
        end
        if (emit) begin
            r_oaddr <= r_addr;
            r_oval  <= on ? r_job.fg : r_job.bg;
            r_olast <= (r_x == r_job.last_x);
        end
    end

    assign o_pix.valid         = r_ov;
    assign o_pix.pixel_address = r_oaddr;
    assign o_pix.pixel_value   = r_oval;
    assign o_pix.last_pixel    = r_olast;

endmodule

// ===== sv/glyph_cell_blitter_top.sv =====
// Glyph cell blitter: draws one pixel row of a character cell per input item.
// i_row (valid/ready) takes a row item: cell position, colors, inverse flag,
// glyph size, row index and 64 glyph bits, MSB first. o_pix (valid/ready)
// gives one framebuffer write per visible pixel, left to right, with
// last_pixel on the final write of the row. Rows that are off screen,
// beyond the cell height or fully clipped give no write at all.
// Cell size, screen size and line stride are set over the APB port
// (byte addresses 0, 4, 8, 12, 16); write them only while the block is idle.
// An item passes the front pipeline, the queue and the stepper job register
// before the output register raises o_pix.valid. Throughput: one pixel per
// cycle from the pixel stepper while o_pix.ready is high; it takes the next
// queued row as it ends one. Items that give no write never reach the queue.
// A 4-entry queue parts the front pipeline from the stepper; a stalled
// receiver holds the output register and backs up the queue, then i_row.
// Reset is synchronous: all items in flight are dropped and the registers
// return to 8x16 cells on a 640x480 screen with stride 640.
module glyph_cell_blitter_top #(
    parameter int MAX_CELL_DIM = gcb_pkg::MAX_CELL_DIM,
    parameter int FB_ADDR_BITS = gcb_pkg::FB_ADDR_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gcb_row_if.sink                       i_row,
    gcb_pix_if.source                     o_pix,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [gcb_pkg::PADDR_BITS-1:0] i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    gcb_pkg::t_cfg    r_cfg;
    gcb_pkg::t_job    f_job, q_job;
    gcb_pkg::t_q_stat q_stat;
    logic [FB_ADDR_BITS-1:0] f_addr, q_addr;
    logic             q_push, q_pop, cfg_wr;
    logic [2:0]       reg_idx;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[4:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_cols     <= gcb_pkg::RST_CELL_COLS;
            r_cfg.cell_rows     <= gcb_pkg::RST_CELL_ROWS;
            r_cfg.screen_width  <= gcb_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height <= gcb_pkg::RST_SCREEN_HEIGHT;
            r_cfg.line_stride   <= gcb_pkg::RST_LINE_STRIDE;
        end else if (cfg_wr) begin
            case (reg_idx)
                gcb_pkg::REG_CELL_COLS:     r_cfg.cell_cols     <= i_pwdata[6:0];
                gcb_pkg::REG_CELL_ROWS:     r_cfg.cell_rows     <= i_pwdata[6:0];
                gcb_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_pwdata[12:0];
                gcb_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_pwdata[12:0];
                gcb_pkg::REG_LINE_STRIDE:   r_cfg.line_stride   <= i_pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gcb_pkg::REG_CELL_COLS:     o_prdata = 32'(r_cfg.cell_cols);
            gcb_pkg::REG_CELL_ROWS:     o_prdata = 32'(r_cfg.cell_rows);
            gcb_pkg::REG_SCREEN_WIDTH:  o_prdata = 32'(r_cfg.screen_width);
            gcb_pkg::REG_SCREEN_HEIGHT: o_prdata = 32'(r_cfg.screen_height);
            gcb_pkg::REG_LINE_STRIDE:   o_prdata = 32'(r_cfg.line_stride);
            default:                    o_prdata = '0;
        endcase
    end

    gcb_front #(
        .MAX_DIM (MAX_CELL_DIM),
        .AB      (FB_ADDR_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_row    (i_row),
        .i_cfg    (r_cfg),
        .i_q_full (q_stat.full),
        .o_push   (q_push),
        .o_job    (f_job),
        .o_addr   (f_addr)
    );

    gcb_queue #(
        .AB (FB_ADDR_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_addr  (f_addr),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_addr  (q_addr),
        .o_stat  (q_stat)
    );

    gcb_back #(
        .AB (FB_ADDR_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_addr  (q_addr),
        .i_stat  (q_stat),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && reg_idx == gcb_pkg::REG_LINE_STRIDE)
        |=> r_cfg.line_stride == $past(i_pwdata[13:0]))
        else $error("line stride write lost");

endmodule
